// File: rtl/umon_pkg.sv
package umon_pkg;

    localparam int TAG_W = 48;
    localparam int CNT_W = 32;
    localparam int CURVE_W = 37;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [CURVE_W-1:0] CURVE_MAX = {CURVE_W{1'b1}};

    typedef enum logic [1:0] {
        KIND_ACCESS = 2'd0,
        KIND_CURVE  = 2'd1,
        KIND_START  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    // one miss-curve value on its way to the result ports
    typedef struct packed {
        logic               valid;
        logic [4:0]         index;
        logic [CURVE_W-1:0] value;
        logic               last;
    } curve_t;

endpackage

// File: rtl/umon_lookup.sv
module umon_lookup #(
    parameter int SETS = 16,
    parameter int WAYS = 16,
    localparam int SW = (SETS > 1) ? $clog2(SETS) : 1,
    localparam int RW = $clog2(WAYS)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req,
    input  logic [umon_pkg::TAG_W-1:0] addr,
    input  logic [SW-1:0]              set,
    output logic                       idle,
    output logic                       done,
    output logic                       hit,
    output logic [RW-1:0]              pos
);
    import umon_pkg::*;

    typedef struct packed {
        logic [WAYS-1:0][TAG_W-1:0] tag;
        logic [WAYS-1:0][RW-1:0]    rank;
    } row_t;

    typedef enum logic [3:0] {
        L_CLEAR = 4'b0001,
        L_IDLE  = 4'b0010,
        L_READ  = 4'b0100,
        L_WRITE = 4'b1000
    } lk_state_t;

    row_t               mem [SETS];
    row_t               rd_row_reg;
    row_t               wr_row;
    logic               we;
    logic [SW-1:0]      waddr;
    lk_state_t          state_reg, state_next;
    logic [SW-1:0]      clr_reg, clr_next;
    logic [TAG_W-1:0]   addr_reg;
    logic [SW-1:0]      set_reg;
    logic               hit_reg;
    logic [RW-1:0]      pos_reg;
    logic [WAYS-1:0]    rank_hit;
    logic               hit_c;
    logic [RW-1:0]      pos_c;

    function automatic row_t init_row();
        row_t r;
        r = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            r.rank[w] = RW'(w);
        end
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wr_row;
        end
        if (req && state_reg == L_IDLE)
        begin
            rd_row_reg <= mem[set];
        end
    end

    // find the matching way nearest MRU
    always_comb
    begin
        rank_hit = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            for (int r = 0; r < WAYS; r++)
            begin
                if (rd_row_reg.tag[w] == addr_reg && rd_row_reg.rank[w] == RW'(r))
                begin
                    rank_hit[r] = 1'b1;
                end
            end
        end
        hit_c = 1'b0;
        pos_c = RW'(WAYS - 1);
        for (int r = 0; r < WAYS; r++)
        begin
            if (rank_hit[r] && !hit_c)
            begin
                pos_c = RW'(r);
                hit_c = 1'b1;
            end
        end
    end

    // ranks form a permutation, so the way at rank pos is the one to promote
    always_comb
    begin
        wr_row = rd_row_reg;
        for (int w = 0; w < WAYS; w++)
        begin
            if (rd_row_reg.rank[w] == pos_reg)
            begin
                wr_row.rank[w] = '0;
                if (!hit_reg)
                begin
                    wr_row.tag[w] = addr_reg;
                end
            end
            else if (rd_row_reg.rank[w] < pos_reg)
            begin
                wr_row.rank[w] = rd_row_reg.rank[w] + 1'b1;
            end
        end
        if (state_reg == L_CLEAR)
        begin
            wr_row = init_row();
        end
    end

    assign we    = (state_reg == L_CLEAR) || (state_reg == L_WRITE);
    assign waddr = (state_reg == L_CLEAR) ? clr_reg : set_reg;

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        case (state_reg)
            L_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == SW'(SETS - 1))
                begin
                    state_next = L_IDLE;
                end
            end
            L_IDLE:
            begin
                if (req)
                begin
                    state_next = L_READ;
                end
            end
            L_READ:  state_next = L_WRITE;
            L_WRITE: state_next = L_IDLE;
            default: state_next = L_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req && state_reg == L_IDLE)
        begin
            addr_reg <= addr;
            set_reg  <= set;
        end
        if (state_reg == L_READ)
        begin
            hit_reg <= hit_c;
            pos_reg <= pos_c;
        end
    end

    assign idle = (state_reg == L_IDLE);
    assign done = (state_reg == L_WRITE);
    assign hit  = hit_reg;
    assign pos  = pos_reg;

endmodule

// File: rtl/umon_counter.sv
module umon_counter #(
    parameter int WAYS = 16,
    localparam int RW = $clog2(WAYS),
    localparam int AW = $clog2(WAYS + 1),
    localparam int TOTW = umon_pkg::CNT_W + AW
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             inc,
    input  logic             inc_hit,
    input  logic [RW-1:0]    inc_pos,
    input  logic             curve_req,
    input  logic             clear_req,
    output logic             idle,
    output umon_pkg::curve_t curve
);
    import umon_pkg::*;

    typedef enum logic [4:0] {
        C_IDLE = 5'b00001,
        C_INC  = 5'b00010,
        C_SUM  = 5'b00100,
        C_EMIT = 5'b01000,
        C_SUB  = 5'b10000
    } cnt_state_t;

    logic [CNT_W-1:0] cnt_mem [WAYS];
    logic [CNT_W-1:0] rd_reg;
    logic             rd_vld_reg;
    logic [WAYS-1:0]  vld_reg;
    logic [CNT_W-1:0] miss_reg;
    cnt_state_t       state_reg;
    logic [RW-1:0]    pos_reg;
    logic [AW-1:0]    a_reg;
    logic             dv_reg;
    logic [TOTW-1:0]  total_reg;
    logic [CNT_W-1:0] rd_val;
    logic             re;
    logic [RW-1:0]    raddr;
    logic             a_end;
    logic [39:0]      tot_ext;
    logic [7:0]       a_ext;

    assign a_end  = (a_reg == AW'(WAYS));
    assign rd_val = rd_vld_reg ? rd_reg : '0;
    assign re     = (state_reg == C_IDLE && inc && inc_hit)
                 || ((state_reg == C_SUM || state_reg == C_EMIT) && !a_end);
    assign raddr  = (state_reg == C_IDLE) ? inc_pos : a_reg[RW-1:0];

    always_ff @(posedge clk)
    begin
        if (state_reg == C_INC)
        begin
            cnt_mem[pos_reg] <= (rd_val == CNT_MAX) ? rd_val : rd_val + 1'b1;
        end
        if (re)
        begin
            rd_reg <= cnt_mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= C_IDLE;
            vld_reg    <= '0;
            miss_reg   <= '0;
            rd_vld_reg <= 1'b0;
            dv_reg     <= 1'b0;
            a_reg      <= '0;
        end
        else
        begin
            if (re)
            begin
                rd_vld_reg <= vld_reg[raddr];
            end
            case (state_reg)
                C_IDLE:
                begin
                    if (inc && inc_hit)
                    begin
                        state_reg <= C_INC;
                    end
                    else if (inc && miss_reg != CNT_MAX)
                    begin
                        miss_reg <= miss_reg + 1'b1;
                    end
                    if (curve_req)
                    begin
                        state_reg <= C_SUM;
                        a_reg     <= '0;
                        dv_reg    <= 1'b0;
                    end
                    if (clear_req)
                    begin
                        vld_reg  <= '0;
                        miss_reg <= '0;
                    end
                end
                C_INC:
                begin
                    vld_reg[pos_reg] <= 1'b1;
                    state_reg        <= C_IDLE;
                end
                C_SUM:
                begin
                    dv_reg <= !a_end;
                    if (!a_end)
                    begin
                        a_reg <= a_reg + 1'b1;
                    end
                    else if (dv_reg)
                    begin
                        a_reg     <= '0;
                        state_reg <= C_EMIT;
                    end
                end
                C_EMIT:
                begin
                    state_reg <= a_end ? C_IDLE : C_SUB;
                end
                C_SUB:
                begin
                    a_reg     <= a_reg + 1'b1;
                    state_reg <= C_EMIT;
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == C_IDLE && inc)
        begin
            pos_reg <= inc_pos;
        end
        if (state_reg == C_IDLE && curve_req)
        begin
            total_reg <= TOTW'(miss_reg);
        end
        else if (state_reg == C_SUM && dv_reg)
        begin
            total_reg <= total_reg + TOTW'(rd_val);
        end
        else if (state_reg == C_SUB)
        begin
            total_reg <= total_reg - TOTW'(rd_val);
        end
    end

    assign tot_ext = 40'(total_reg);
    assign a_ext   = 8'(a_reg);

    always_comb
    begin
        curve.valid = (state_reg == C_EMIT);
        curve.index = a_ext[4:0];
        curve.value = (tot_ext > 40'(CURVE_MAX)) ? CURVE_MAX : tot_ext[CURVE_W-1:0];
        curve.last  = a_end;
    end

    assign idle = (state_reg == C_IDLE);

endmodule

// File: rtl/lru_stack_utility_monitor.sv
// LRU stack-distance utility monitor over shadow tags.
//
// Command channel: present kind, line_addr and set_index with start high;
// the item is taken at a rising edge where start is high and busy is low.
//   access       one result in the L_WRITE state that follows L_READ: hit and
//                stack_position, last high. busy stays high longer on a
//                hit than on a miss, while the hit counter is written back.
//   miss curve   WAYS+1 results, curve_index 0..WAYS. A sweep of the hit
//                counter memory builds the total, then the values come out
//                in index order, each followed by taking off the counter of
//                its position; busy until the last value is out.
//   start        clears the counters, gives no result.
// Each result sits on the ports for exactly one cycle with valid high; the
// receiver cannot stall it. The set memory holds one row per set (all tags
// and ranks) and is read, updated and written back once per access.
// After reset a clearing pass writes every set row, with busy high the whole
// time.
module lru_stack_utility_monitor #(
    parameter int SETS = 16,
    parameter int WAYS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   kind,
    input  logic [umon_pkg::TAG_W-1:0]   line_addr,
    input  logic [3:0]                   set_index,
    output logic                         valid,
    output logic                         hit,
    output logic [3:0]                   stack_position,
    output logic [4:0]                   curve_index,
    output logic [umon_pkg::CURVE_W-1:0] curve_value,
    output logic                         last
);
    import umon_pkg::*;

    localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int RW = $clog2(WAYS);

    logic          accept;
    kind_t         kind_c;
    logic          lk_idle, lk_done, lk_hit;
    logic [RW-1:0] lk_pos;
    logic          cnt_idle;
    curve_t        curve;
    logic [SW-1:0] set_c;

    // fold the 4-bit set index into 0..SETS-1 by counting with wrap
    function automatic logic [SW-1:0] fold_set(input logic [3:0] s);
        logic [SW-1:0] res;
        int            c;
        res = '0;
        c   = 0;
        for (int i = 0; i < 16; i++)
        begin
            if (s == 4'(i))
            begin
                res = SW'(c);
            end
            c = (c == SETS - 1) ? 0 : c + 1;
        end
        return res;
    endfunction

    assign kind_c = kind_t'(kind);
    assign set_c  = fold_set(set_index);
    assign busy   = !(lk_idle && cnt_idle);
    assign accept = start && !busy;

    umon_lookup #(.SETS(SETS), .WAYS(WAYS)) u_lookup (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (accept && kind_c == KIND_ACCESS),
        .addr  (line_addr),
        .set   (set_c),
        .idle  (lk_idle),
        .done  (lk_done),
        .hit   (lk_hit),
        .pos   (lk_pos)
    );

    // hand each finished access to the counters
    umon_counter #(.WAYS(WAYS)) u_counter (
        .clk       (clk),
        .rst_n     (rst_n),
        .inc       (lk_done),
        .inc_hit   (lk_hit),
        .inc_pos   (lk_pos),
        .curve_req (accept && kind_c == KIND_CURVE),
        .clear_req (accept && kind_c == KIND_START),
        .idle      (cnt_idle),
        .curve     (curve)
    );

    // merge the two result sources; they never fire together
    always_comb
    begin
        valid          = lk_done || curve.valid;
        hit            = lk_done && lk_hit;
        stack_position = lk_done ? 4'(lk_pos) : 4'd0;
        curve_index    = curve.valid ? curve.index : 5'd0;
        curve_value    = curve.valid ? curve.value : '0;
        last           = lk_done || (curve.valid && curve.last);
    end

endmodule

// File: tb/sv/tb_lru_stack_utility_monitor.sv
`timescale 1ns / 1ps

module tb_lru_stack_utility_monitor;
    import umon_pkg::*;

    localparam int SETS = 16;
    localparam int WAYS = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 20;

    // one expected result, field by field as the ports carry it
    typedef struct {
        logic               hit;
        logic [3:0]         pos;
        logic [4:0]         idx;
        logic [CURVE_W-1:0] value;
        logic               last;
    } umon_result_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         kind;
    logic [TAG_W-1:0]   line_addr;
    logic [3:0]         set_index;
    logic               valid;
    logic               hit;
    logic [3:0]         stack_position;
    logic [4:0]         curve_index;
    logic [CURVE_W-1:0] curve_value;
    logic               last;

    lru_stack_utility_monitor #(
        .SETS(SETS),
        .WAYS(WAYS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .kind(kind),
        .line_addr(line_addr),
        .set_index(set_index),
        .valid(valid),
        .hit(hit),
        .stack_position(stack_position),
        .curve_index(curve_index),
        .curve_value(curve_value),
        .last(last)
    );

    // shadow copy of the monitor state
    logic [TAG_W-1:0] shadow_tags [SETS][WAYS];
    int               shadow_rank [SETS][WAYS];
    logic [CNT_W-1:0] shadow_hits [WAYS];
    logic [CNT_W-1:0] shadow_misses;

    umon_result_t     pending_results[$];
    logic [TAG_W-1:0] addr_pool [20];

    int  mismatch_count;
    int  cycle_count;
    int  items_sent;
    int  results_seen;
    int  hits_seen;
    int  sender_idle_pct;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // give up on a hang: the slowest correct run is far below this
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [CNT_W-1:0] sat_bump(logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    // Advance the shadow state by one accepted item and queue its results.
    task automatic predict_item(logic [1:0] k, logic [TAG_W-1:0] addr, logic [3:0] s);
        int               set_sel;
        int               way;
        int               pos;
        bit               found;
        logic [CURVE_W+1:0] total;
        umon_result_t     r;
        set_sel = s % SETS;
        way = 0;
        pos = WAYS;
        found = 0;
        if (kind_t'(k) == KIND_ACCESS) begin
            // nearest-MRU match wins when several ways hold the same tag
            for (int w = 0; w < WAYS; w++) begin
                if (shadow_tags[set_sel][w] == addr && shadow_rank[set_sel][w] < pos) begin
                    pos = shadow_rank[set_sel][w];
                    way = w;
                    found = 1;
                end
            end
            if (found) begin
                shadow_hits[pos] = sat_bump(shadow_hits[pos]);
            end
            else begin
                pos = WAYS - 1;
                for (int w = 0; w < WAYS; w++)
                    if (shadow_rank[set_sel][w] == WAYS - 1)
                        way = w;
                shadow_misses = sat_bump(shadow_misses);
                shadow_tags[set_sel][way] = addr;
            end
            for (int w = 0; w < WAYS; w++)
                if (shadow_rank[set_sel][w] < pos)
                    shadow_rank[set_sel][w]++;
            shadow_rank[set_sel][way] = 0;
            r.hit = found;
            r.pos = pos[3:0];
            r.idx = '0;
            r.value = '0;
            r.last = 1'b1;
            pending_results.push_back(r);
        end
        else if (kind_t'(k) == KIND_CURVE) begin
            umon_result_t curve [WAYS+1];
            // build from the top: value WAYS is the misses alone
            total = shadow_misses;
            for (int i = WAYS; i >= 0; i--) begin
                curve[i].hit = 1'b0;
                curve[i].pos = '0;
                curve[i].idx = i[4:0];
                curve[i].value = (total > CURVE_MAX) ? CURVE_MAX : total[CURVE_W-1:0];
                curve[i].last = (i == WAYS);
                if (i > 0)
                    total += shadow_hits[i-1];
            end
            for (int i = 0; i <= WAYS; i++)
                pending_results.push_back(curve[i]);
        end
        else if (kind_t'(k) == KIND_START) begin
            for (int w = 0; w < WAYS; w++)
                shadow_hits[w] = '0;
            shadow_misses = '0;
        end
    endtask

    // Drive one item, hold it until the block takes it, then predict.
    // start stays high into the next item unless the sender idles.
    task automatic send_item(kind_t k, logic [TAG_W-1:0] addr, logic [3:0] s);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            start = 1'b0;
            kind = 2'($urandom);
            line_addr = TAG_W'({$urandom, $urandom});
            set_index = 4'($urandom);
            @(negedge clk);
        end
        start = 1'b1;
        kind = k;
        line_addr = addr;
        set_index = s;
        forever begin
            @(posedge clk);
            if (!busy)
                break;
        end
        predict_item(k, addr, s);
        if (k != KIND_NONE)
            items_sent++;
    endtask

    // Drop start and let the block drain before a phase change.
    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Every result is checked against the oldest expectation.
    always @(posedge clk) begin
        umon_result_t want;
        if (rst_n && valid) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: hit=%0d pos=%0d idx=%0d value=%0d",
                       hit, stack_position, curve_index, curve_value);
                mismatch_count++;
            end
            else begin
                want = pending_results.pop_front();
                if (hit) hits_seen++;
                if (hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, hit);
                    mismatch_count++;
                end
                if (stack_position !== want.pos) begin
                    $error("stack_position: expected %0d, got %0d", want.pos, stack_position);
                    mismatch_count++;
                end
                if (curve_index !== want.idx) begin
                    $error("curve_index: expected %0d, got %0d", want.idx, curve_index);
                    mismatch_count++;
                end
                if (curve_value !== want.value) begin
                    $error("curve_value: expected %0d, got %0d", want.value, curve_value);
                    mismatch_count++;
                end
                if (last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, last);
                    mismatch_count++;
                end
            end
        end
    end

    // Line zero hits never-filled ways right after reset (no valid bits),
    // and every way of a fresh set holds the same zero tag.
    task automatic test_zero_tags();
        send_item(KIND_ACCESS, '0, 4'd0);
        send_item(KIND_ACCESS, '0, 4'd15);
        send_item(KIND_ACCESS, '0, 4'd0);
    endtask

    // Fill every way of one set, then hit the deepest position and miss.
    task automatic test_deep_stack();
        for (int i = 1; i <= WAYS; i++)
            send_item(KIND_ACCESS, TAG_W'(i), 4'd5);
        send_item(KIND_ACCESS, TAG_W'(1), 4'd5);
        send_item(KIND_ACCESS, TAG_W'(100), 4'd5);
    endtask

    // Extreme addresses, the unused kind, a curve read and interval clear.
    task automatic test_curve_and_interval();
        send_item(KIND_ACCESS, {TAG_W{1'b1}}, 4'd15);
        send_item(KIND_ACCESS, {TAG_W{1'b1}}, 4'd15);
        send_item(KIND_NONE, {TAG_W{1'b1}}, 4'd15);
        send_item(KIND_CURVE, '0, 4'd0);
        send_item(KIND_START, '0, 4'd0);
        send_item(KIND_CURVE, {TAG_W{1'b1}}, 4'd15);
    endtask

    // Random traffic: mostly accesses to a small address pool so stack
    // positions spread over the whole depth; some curve reads and clears.
    task automatic test_random(int count);
        int          roll;
        kind_t       k;
        logic [TAG_W-1:0] a;
        logic [3:0]  s;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            k = (roll < 80) ? KIND_ACCESS : (roll < 88) ? KIND_CURVE :
                (roll < 94) ? KIND_START : KIND_NONE;
            a = ($urandom_range(99) < 85) ? addr_pool[$urandom_range(19)]
                                          : TAG_W'({$urandom, $urandom});
            s = ($urandom_range(99) < 70) ? 4'($urandom_range(3)) : 4'($urandom);
            send_item(k, a, s);
        end
    endtask

    initial begin
        mismatch_count = 0;
        cycle_count = 0;
        items_sent = 0;
        results_seen = 0;
        hits_seen = 0;
        sender_idle_pct = 0;
        start = 1'b0;
        kind = '0;
        line_addr = '0;
        set_index = '0;
        rst_n = 1'b0;
        for (int s = 0; s < SETS; s++)
            for (int w = 0; w < WAYS; w++) begin
                shadow_tags[s][w] = '0;
                shadow_rank[s][w] = w;
            end
        for (int w = 0; w < WAYS; w++)
            shadow_hits[w] = '0;
        shadow_misses = '0;
        for (int i = 0; i < 20; i++)
            addr_pool[i] = TAG_W'({$urandom, $urandom});
        addr_pool[0] = '0;
        addr_pool[1] = {TAG_W{1'b1}};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_zero_tags();
        test_deep_stack();
        test_curve_and_interval();
        drain();

        sender_idle_pct = 38;
        test_random(131);
        drain();
        sender_idle_pct = 67;
        test_random(131);
        drain();
        sender_idle_pct = 0;
        test_random(131);
        drain();

        $display("Covered %0d items and %0d results (%0d access hits),",
                 items_sent, results_seen, hits_seen);
        $display("with accesses, curve reads, interval clears and the unused kind.");
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
